[sv/sll_pkg.sv]
package sll_pkg;

  localparam int KindW = 2;
  localparam int PosW  = 7;
  localparam int DataW = 32;
  localparam int StatW = 2;
  localparam int LenW  = 7;

  localparam logic [KindW-1:0] KIND_INSERT = 2'd0;
  localparam logic [KindW-1:0] KIND_DELETE = 2'd1;
  localparam logic [KindW-1:0] KIND_READ   = 2'd2;

  localparam logic [StatW-1:0] ST_OK      = 2'd0;
  localparam logic [StatW-1:0] ST_RANGE   = 2'd1;
  localparam logic [StatW-1:0] ST_NO_FREE = 2'd2;

  typedef logic [KindW-1:0]        kind_t;
  typedef logic [PosW-1:0]         pos_t;
  typedef logic signed [DataW-1:0] data_t;
  typedef logic [StatW-1:0]        status_t;
  typedef logic [LenW-1:0]         len_t;

endpackage

[sv/sll_req_if.sv]
interface sll_req_if;
  import sll_pkg::*;

  logic  valid;
  logic  ready;
  kind_t kind;
  pos_t  position;
  data_t value;

  modport source(output valid, kind, position, value, input ready);
  modport sink(input valid, kind, position, value, output ready);
endinterface

[sv/sll_rsp_if.sv]
interface sll_rsp_if;
  import sll_pkg::*;

  logic    valid;
  logic    ready;
  status_t status;
  data_t   read_value;
  len_t    list_length;

  modport source(output valid, status, read_value, list_length, input ready);
  modport sink(input valid, status, read_value, list_length, output ready);
endinterface

[sv/sll_ram.sv]
module sll_ram #(
  parameter int Width = 32,
  parameter int Depth = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

[sv/static_linked_list_engine.sv]
// Static linked list engine: a cursor list with a free chain in one slot array.
// Slot 0 heads the free chain, slot SLOTS-1 heads the data list.
// req_i (valid/ready) carries kind, position and value: insert before a
// 1-based position, delete the entry at a position, or read its value.
// rsp_o (valid/ready) returns status, read_value and the list length.
// Requests are handled one at a time by a sequencer around a link memory with
// one read and one write port; each cycle does one link read. The time from
// accept to result grows with the position, set by the walk along the links;
// a rejected request or an insert into a full list skips the walk.
// After reset the block sweeps the link memory to build the free chain
// with req_i.ready low.
// The result sits in an output register; req_i takes the next request while
// it waits. If the receiver stalls, the next finished result waits in the
// sequencer until the output register frees up.
module static_linked_list_engine #(
  parameter int SLOTS = 128
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  sll_req_if.sink   req_i,
  sll_rsp_if.source rsp_o
);
  import sll_pkg::*;

  localparam int AW   = $clog2(SLOTS);
  localparam int CmpW = ((AW > PosW) ? AW : PosW) + 1;
  localparam logic [AW-1:0] HeadSlot = AW'(SLOTS - 1);
  localparam logic [AW-1:0] FreeSlot = '0;
  localparam logic [AW-1:0] LastFree = AW'(SLOTS - 2);

  typedef enum logic [10:0] {
    S_INIT  = 11'b00000000001,
    S_IDLE  = 11'b00000000010,
    S_ALLOC = 11'b00000000100,
    S_POP   = 11'b00000001000,
    S_WALK  = 11'b00000010000,
    S_LINK  = 11'b00000100000,
    S_UNLK  = 11'b00001000000,
    S_FREE  = 11'b00010000000,
    S_PUSH  = 11'b00100000000,
    S_VAL   = 11'b01000000000,
    S_DONE  = 11'b10000000000
  } state_e;

  state_e          state_q, state_d;
  logic [AW-1:0]   cnt_q, cnt_d;
  logic [AW-1:0]   init_q, init_d;
  logic [AW-1:0]   k_q, k_d;
  logic [AW-1:0]   j_q, j_d;
  logic [PosW-1:0] rem_q, rem_d;
  kind_t           kind_q, kind_d;
  data_t           val_q, val_d;
  status_t         st_q, st_d;
  data_t           rd_q, rd_d;

  logic            ov_q, ov_d;
  status_t         ostat_q, ostat_d;
  data_t           ord_q, ord_d;
  len_t            olen_q, olen_d;

  logic            link_we;
  logic [AW-1:0]   link_waddr, link_wdata, link_raddr, link_rdata;
  logic            val_we;
  logic [AW-1:0]   val_raddr;
  data_t           val_rdata;

  logic [CmpW-1:0] pos_x, cnt_x;
  logic            ins_ok, acc_ok, out_free;

  sll_ram #(.Width(AW), .Depth(SLOTS)) u_link_ram (
    .clk_i  (clk_i),
    .we_i   (link_we),
    .waddr_i(link_waddr),
    .wdata_i(link_wdata),
    .raddr_i(link_raddr),
    .rdata_o(link_rdata)
  );

  sll_ram #(.Width(DataW), .Depth(SLOTS)) u_val_ram (
    .clk_i  (clk_i),
    .we_i   (val_we),
    .waddr_i(j_q),
    .wdata_i(val_q),
    .raddr_i(val_raddr),
    .rdata_o(val_rdata)
  );

  assign pos_x    = CmpW'(req_i.position);
  assign cnt_x    = CmpW'(cnt_q);
  assign ins_ok   = (req_i.position != '0) && (pos_x <= cnt_x + CmpW'(1));
  assign acc_ok   = (req_i.position != '0) && (pos_x <= cnt_x);
  assign out_free = !ov_q || rsp_o.ready;

  assign req_i.ready = (state_q == S_IDLE);

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    init_d     = init_q;
    k_d        = k_q;
    j_d        = j_q;
    rem_d      = rem_q;
    kind_d     = kind_q;
    val_d      = val_q;
    st_d       = st_q;
    rd_d       = rd_q;
    link_we    = 1'b0;
    link_waddr = k_q;
    link_wdata = j_q;
    link_raddr = HeadSlot;
    val_we     = 1'b0;
    val_raddr  = link_rdata;

    unique case (state_q)
      S_INIT: begin
        link_we    = 1'b1;
        link_waddr = init_q;
        link_wdata = (init_q >= LastFree) ? '0 : init_q + AW'(1);
        init_d     = init_q + AW'(1);
        if (init_q == HeadSlot) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (req_i.valid) begin
          kind_d = req_i.kind;
          val_d  = req_i.value;
          st_d   = ST_RANGE;
          rd_d   = '0;
          k_d    = HeadSlot;
          rem_d  = req_i.position - PosW'(1);
          if (req_i.kind == KIND_INSERT && ins_ok) begin
            link_raddr = FreeSlot;
            state_d    = S_ALLOC;
          end else if ((req_i.kind == KIND_DELETE || req_i.kind == KIND_READ) && acc_ok) begin
            link_raddr = HeadSlot;
            state_d    = S_WALK;
          end else begin
            state_d = S_DONE;
          end
        end
      end
      S_ALLOC: begin
        // free chain head arrives; empty chain means full
        if (link_rdata == '0) begin
          st_d    = ST_NO_FREE;
          state_d = S_DONE;
        end else begin
          j_d        = link_rdata;
          link_raddr = link_rdata;
          state_d    = S_POP;
        end
      end
      S_POP: begin
        link_we    = 1'b1;
        link_waddr = FreeSlot;
        link_wdata = link_rdata;
        val_we     = 1'b1;
        link_raddr = HeadSlot;
        state_d    = S_WALK;
      end
      S_WALK: begin
        if (rem_q != '0) begin
          // advance one link
          k_d        = link_rdata;
          link_raddr = link_rdata;
          rem_d      = rem_q - PosW'(1);
        end else if (kind_q == KIND_INSERT) begin
          link_we    = 1'b1;
          link_waddr = j_q;
          link_wdata = link_rdata;
          state_d    = S_LINK;
        end else if (kind_q == KIND_DELETE) begin
          j_d        = link_rdata;
          link_raddr = link_rdata;
          state_d    = S_UNLK;
        end else begin
          state_d = S_VAL;
        end
      end
      S_LINK: begin
        link_we    = 1'b1;
        link_waddr = k_q;
        link_wdata = j_q;
        cnt_d      = cnt_q + AW'(1);
        st_d       = ST_OK;
        state_d    = S_DONE;
      end
      S_UNLK: begin
        link_we    = 1'b1;
        link_waddr = k_q;
        link_wdata = link_rdata;
        link_raddr = FreeSlot;
        state_d    = S_FREE;
      end
      S_FREE: begin
        link_we    = 1'b1;
        link_waddr = j_q;
        link_wdata = link_rdata;
        state_d    = S_PUSH;
      end
      S_PUSH: begin
        link_we    = 1'b1;
        link_waddr = FreeSlot;
        link_wdata = j_q;
        cnt_d      = cnt_q - AW'(1);
        st_d       = ST_OK;
        state_d    = S_DONE;
      end
      S_VAL: begin
        rd_d    = val_rdata;
        st_d    = ST_OK;
        state_d = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    ov_d    = ov_q && !rsp_o.ready;
    ostat_d = ostat_q;
    ord_d   = ord_q;
    olen_d  = olen_q;
    if (state_q == S_DONE && out_free) begin
      ov_d    = 1'b1;
      ostat_d = st_q;
      ord_d   = rd_q;
      olen_d  = LenW'(cnt_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
      cnt_q   <= '0;
      init_q  <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      init_q  <= init_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    k_q     <= k_d;
    j_q     <= j_d;
    rem_q   <= rem_d;
    kind_q  <= kind_d;
    val_q   <= val_d;
    st_q    <= st_d;
    rd_q    <= rd_d;
    ostat_q <= ostat_d;
    ord_q   <= ord_d;
    olen_q  <= olen_d;
  end

  assign rsp_o.valid       = ov_q;
  assign rsp_o.status      = ostat_q;
  assign rsp_o.read_value  = ord_q;
  assign rsp_o.list_length = olen_q;

  a_full_only_when_list_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ALLOC && link_rdata == '0) |-> (cnt_q == LastFree))
    else $error("free chain empty while list not full");

  a_read_value_only_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && rsp_o.status != ST_OK) |-> (rsp_o.read_value == '0))
    else $error("nonzero read_value on failed request");

  a_insert_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_LINK) |=> (cnt_q == $past(cnt_q) + AW'(1)))
    else $error("insert did not grow the list by one");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE) |-> (cnt_q <= LastFree))
    else $error("list length beyond capacity");

endmodule
